>>> hw/rtl/rrs_pkg.sv
// rrs_pkg: types, constants and state encoding for the running range statistics block
// used by rrs_iter_unit and running_range_stats_reservoir_top; no dependencies
package rrs_pkg;

  localparam int unsigned ReservoirDepthDefault = 4096;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned StepW = 7;

  localparam logic [CfgIdxW-1:0] CFG_RNG_SEED = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_CAPACITY = 8'd1;

  localparam logic [12:0] CAPACITY_RESET = 13'd4096;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

  // step counts of the shared unit
  localparam logic [StepW-1:0] STEPS_MEAN_DIV = 7'd33;
  localparam logic [StepW-1:0] STEPS_MOD      = 7'd64;
  localparam logic [StepW-1:0] STEPS_MUL      = 7'd4;

  typedef enum logic [0:0] {
    OP_DIV,
    OP_MUL
  } alu_op_e;

  typedef struct packed {
    logic             start;
    alu_op_e          op;
    logic [StepW-1:0] steps;
  } alu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_M2,
    ST_RNG_A,
    ST_RNG_B,
    ST_MOD,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               not_finite;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        sample_count;
    logic [31:0]        bad_count;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic [31:0]        abs_min_value;
    logic [31:0]        abs_max_value;
    logic signed [31:0] running_mean;
    logic [63:0]        sum_sq_dev;
    logic [11:0]        slot_index;
    logic               slot_written;
    logic               overflow;
  } out_item_t;

endpackage

>>> hw/rtl/rrs_iter_unit.sv
// rrs_iter_unit: shared iterative unit, restoring divider (one quotient bit a cycle)
// and 64x64 shift-add multiplier, 16 multiplier bits per step (low 64 bits); depends on rrs_pkg
module rrs_iter_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rrs_pkg::alu_cmd_t  cmd_i,
  input  logic [63:0]        opa_i,
  input  logic [63:0]        opb_i,
  output rrs_pkg::alu_stat_t stat_o,
  output logic [63:0]        quot_o,
  output logic [31:0]        rem_o,
  output logic [63:0]        prod_o
);

  logic [63:0] x_q, x_d;
  logic [63:0] y_q, y_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] rem_q, rem_d;
  logic [rrs_pkg::StepW-1:0] cnt_q, cnt_d;
  rrs_pkg::alu_op_e op_q, op_d;
  logic busy_q, busy_d;
  logic done_q, done_d;

  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        ge;
  logic [79:0] pp;

  always_comb begin
    rem_sh  = {rem_q, x_q[63]};
    rem_sub = rem_sh - {1'b0, y_q[31:0]};
    ge      = (rem_sh >= {1'b0, y_q[31:0]});
    pp      = {16'd0, x_q} * {64'd0, y_q[15:0]};
  end

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    op_d   = op_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (cmd_i.start) begin
      x_d    = opa_i;
      y_d    = opb_i;
      acc_d  = '0;
      rem_d  = '0;
      cnt_d  = cmd_i.steps;
      op_d   = cmd_i.op;
      busy_d = 1'b1;
    end else if (busy_q) begin
      case (op_q)
        rrs_pkg::OP_DIV: begin
          rem_d = ge ? rem_sub[31:0] : rem_sh[31:0];
          x_d   = {x_q[62:0], ge};
        end
        default: begin
          acc_d = acc_q + pp[63:0];
          x_d   = {x_q[47:0], 16'd0};
          y_d   = {16'd0, y_q[63:16]};
        end
      endcase
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == {{(rrs_pkg::StepW-1){1'b0}}, 1'b1}) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= rrs_pkg::OP_DIV;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = x_q;
  assign rem_o       = rem_q;
  assign prod_o      = acc_q;

endmodule

>>> hw/rtl/running_range_stats_reservoir_top.sv
// running_range_stats_reservoir_top: running min/max, Welford mean and M2, reservoir slot choice
// depends on rrs_pkg and rrs_iter_unit
//
// Usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) takes one Q16.16 sample and a
//   not-finite flag per transaction. out channel (out_valid_o/out_ready_i/out_data_o)
//   returns one result per input: the statistics after that sample and the reservoir
//   slot to store it in (slot_written), so the reservoir memory lives outside.
//   cfg channel writes rng_seed (index 0, also loads the generator) and capacity
//   (index 1); cfg_ready_o is always high, other indexes are ignored.
// Sequence:
//   one item at a time; in_ready_o is high only while the sequencer is idle.
//   non-finite or ignored samples go straight to ST_FINISH, which registers the
//   result once the output register is free. finite samples while the reservoir
//   fills: a 33-step mean divide plus a 4-step multiply, then ST_FINISH.
//   after that two more 4-step multiplies for the generator and a 64-step modulo
//   follow, all on the one shared unit.
// Reset clears all statistics, the generator state to 0 and capacity to 4096.
// The output register holds a result until taken; a new sample may be accepted
// meanwhile, and the sequencer waits at its end only if the previous result is
// still not taken.
module running_range_stats_reservoir_top #(
  parameter int unsigned RESERVOIR_DEPTH = rrs_pkg::ReservoirDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  rrs_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rrs_pkg::out_item_t           out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rrs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [63:0]                  cfg_data_i
);

  localparam int unsigned FillW = $clog2(RESERVOIR_DEPTH + 1);
  localparam logic [31:0] Depth32 = 32'(RESERVOIR_DEPTH);

  rrs_pkg::state_e state_q, state_d;

  logic [31:0]        count_q, count_d;
  logic [31:0]        bad_q, bad_d;
  logic signed [31:0] min_q, min_d;
  logic signed [31:0] max_q, max_d;
  logic [31:0]        amin_q, amin_d;
  logic [31:0]        amax_q, amax_d;
  logic signed [31:0] mean_q, mean_d;
  logic [63:0]        m2_q, m2_d;
  logic [63:0]        rng_q, rng_d;
  logic               ovf_q, ovf_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [12:0]        cap_q, cap_d;
  logic signed [31:0] samp_q, samp_d;
  logic               dneg_q, dneg_d;
  logic [32:0]        dmag_q, dmag_d;
  logic               wr_q, wr_d;
  logic [11:0]        slot_q, slot_d;
  logic               out_valid_q, out_valid_d;
  rrs_pkg::out_item_t out_q, out_d;

  rrs_pkg::alu_cmd_t  cmd;
  rrs_pkg::alu_stat_t stat;
  logic [63:0]        opa, opb;
  logic [63:0]        quot, prod;
  logic [31:0]        rem;

  logic               in_take;
  logic               out_free;
  logic [31:0]        smag;
  logic [32:0]        delta;
  logic [33:0]        new_mean;
  logic [32:0]        dev;
  logic [32:0]        dev_mag;
  logic [64:0]        m2_sum;
  logic [31:0]        cap32;
  logic [31:0]        fill32;
  logic [63:0]        rng_next;

  rrs_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .opa_i  (opa),
    .opb_i  (opb),
    .stat_o (stat),
    .quot_o (quot),
    .rem_o  (rem),
    .prod_o (prod)
  );

  assign in_ready_o  = (state_q == rrs_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign in_take     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    smag     = in_data_i.sample[31] ? (32'd0 - in_data_i.sample) : in_data_i.sample;
    delta    = {in_data_i.sample[31], in_data_i.sample} - {mean_q[31], mean_q};
    new_mean = dneg_q ? ({{2{mean_q[31]}}, mean_q} - {1'b0, quot[32:0]})
                      : ({{2{mean_q[31]}}, mean_q} + {1'b0, quot[32:0]});
    dev      = {samp_q[31], samp_q} - {new_mean[31], new_mean[31:0]};
    dev_mag  = dev[32] ? (33'd0 - dev) : dev;
    m2_sum   = {1'b0, m2_q} + {1'b0, prod};
    cap32    = ({19'd0, cap_q} > Depth32) ? Depth32 : {19'd0, cap_q};
    fill32   = 32'(fill_q);
    rng_next = rng_q + rrs_pkg::GOLDEN_GAMMA;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrs_pkg::ST_IDLE: begin
        if (in_take) begin
          if (!in_data_i.not_finite && (count_q != '1)) begin
            state_d = rrs_pkg::ST_DIV;
          end else begin
            state_d = rrs_pkg::ST_FINISH;
          end
        end
      end
      rrs_pkg::ST_DIV: begin
        if (stat.done) state_d = rrs_pkg::ST_MUL_M2;
      end
      rrs_pkg::ST_MUL_M2: begin
        if (stat.done) begin
          state_d = (fill32 < cap32) ? rrs_pkg::ST_FINISH : rrs_pkg::ST_RNG_A;
        end
      end
      rrs_pkg::ST_RNG_A: begin
        if (stat.done) state_d = rrs_pkg::ST_RNG_B;
      end
      rrs_pkg::ST_RNG_B: begin
        if (stat.done) state_d = rrs_pkg::ST_MOD;
      end
      rrs_pkg::ST_MOD: begin
        if (stat.done) state_d = rrs_pkg::ST_FINISH;
      end
      rrs_pkg::ST_FINISH: begin
        if (out_free) state_d = rrs_pkg::ST_IDLE;
      end
      default: state_d = rrs_pkg::ST_IDLE;
    endcase
  end

  // datapath and unit commands
  always_comb begin
    count_d     = count_q;
    bad_d       = bad_q;
    min_d       = min_q;
    max_d       = max_q;
    amin_d      = amin_q;
    amax_d      = amax_q;
    mean_d      = mean_q;
    m2_d        = m2_q;
    rng_d       = rng_q;
    ovf_d       = ovf_q;
    fill_d      = fill_q;
    cap_d       = cap_q;
    samp_d      = samp_q;
    dneg_d      = dneg_q;
    dmag_d      = dmag_q;
    wr_d        = wr_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    cmd.start   = 1'b0;
    cmd.op      = rrs_pkg::OP_DIV;
    cmd.steps   = rrs_pkg::STEPS_MEAN_DIV;
    opa         = '0;
    opb         = '0;

    unique case (state_q)
      rrs_pkg::ST_IDLE: begin
        if (in_take) begin
          samp_d = in_data_i.sample;
          wr_d   = 1'b0;
          slot_d = '0;
          if (in_data_i.not_finite) begin
            if (bad_q == '1) ovf_d = 1'b1;
            else bad_d = bad_q + 1'b1;
          end else if (count_q == '1) begin
            ovf_d = 1'b1;
          end else begin
            if (count_q == '0) begin
              min_d  = in_data_i.sample;
              max_d  = in_data_i.sample;
              amin_d = smag;
              amax_d = smag;
            end else begin
              if (in_data_i.sample < min_q) min_d = in_data_i.sample;
              if (in_data_i.sample > max_q) max_d = in_data_i.sample;
              if (smag > amax_q) amax_d = smag;
              if (smag < amin_q) amin_d = smag;
            end
            count_d   = count_q + 1'b1;
            dneg_d    = delta[32];
            dmag_d    = delta[32] ? (33'd0 - delta) : delta;
            cmd.start = 1'b1;
            cmd.op    = rrs_pkg::OP_DIV;
            cmd.steps = rrs_pkg::STEPS_MEAN_DIV;
            opa       = {dmag_d, 31'd0};
            opb       = {32'd0, count_d};
          end
        end
      end
      rrs_pkg::ST_DIV: begin
        if (stat.done) begin
          mean_d    = new_mean[31:0];
          cmd.start = 1'b1;
          cmd.op    = rrs_pkg::OP_MUL;
          cmd.steps = rrs_pkg::STEPS_MUL;
          opa       = {31'd0, dmag_q};
          opb       = {31'd0, dev_mag};
        end
      end
      rrs_pkg::ST_MUL_M2: begin
        if (stat.done) begin
          if (m2_sum[64]) begin
            m2_d  = '1;
            ovf_d = 1'b1;
          end else begin
            m2_d = m2_sum[63:0];
          end
          if (fill32 < cap32) begin
            slot_d = fill32[11:0];
            fill_d = fill_q + 1'b1;
            wr_d   = 1'b1;
          end else begin
            rng_d     = rng_next;
            cmd.start = 1'b1;
            cmd.op    = rrs_pkg::OP_MUL;
            cmd.steps = rrs_pkg::STEPS_MUL;
            opa       = rng_next ^ (rng_next >> 30);
            opb       = rrs_pkg::MIX_MUL_A;
          end
        end
      end
      rrs_pkg::ST_RNG_A: begin
        if (stat.done) begin
          cmd.start = 1'b1;
          cmd.op    = rrs_pkg::OP_MUL;
          cmd.steps = rrs_pkg::STEPS_MUL;
          opa       = prod ^ (prod >> 27);
          opb       = rrs_pkg::MIX_MUL_B;
        end
      end
      rrs_pkg::ST_RNG_B: begin
        if (stat.done) begin
          cmd.start = 1'b1;
          cmd.op    = rrs_pkg::OP_DIV;
          cmd.steps = rrs_pkg::STEPS_MOD;
          opa       = prod ^ (prod >> 31);
          opb       = {32'd0, count_q};
        end
      end
      rrs_pkg::ST_MOD: begin
        if (stat.done && (rem < cap32)) begin
          wr_d   = 1'b1;
          slot_d = rem[11:0];
        end
      end
      rrs_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.sample_count   = count_q;
          out_d.bad_count      = bad_q;
          out_d.min_value      = min_q;
          out_d.max_value      = max_q;
          out_d.abs_min_value  = amin_q;
          out_d.abs_max_value  = amax_q;
          out_d.running_mean   = mean_q;
          out_d.sum_sq_dev     = m2_q;
          out_d.slot_index     = slot_q;
          out_d.slot_written   = wr_q;
          out_d.overflow       = ovf_q;
        end
      end
      default: ;
    endcase

    // register writes must arrive only while idle; the block itself does not enforce this
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rrs_pkg::CFG_RNG_SEED: rng_d = cfg_data_i;
        rrs_pkg::CFG_CAPACITY: cap_d = cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrs_pkg::ST_IDLE;
      count_q     <= '0;
      bad_q       <= '0;
      min_q       <= '0;
      max_q       <= '0;
      amin_q      <= '0;
      amax_q      <= '0;
      mean_q      <= '0;
      m2_q        <= '0;
      rng_q       <= '0;
      ovf_q       <= 1'b0;
      fill_q      <= '0;
      cap_q       <= rrs_pkg::CAPACITY_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      bad_q       <= bad_d;
      min_q       <= min_d;
      max_q       <= max_d;
      amin_q      <= amin_d;
      amax_q      <= amax_d;
      mean_q      <= mean_d;
      m2_q        <= m2_d;
      rng_q       <= rng_d;
      ovf_q       <= ovf_d;
      fill_q      <= fill_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q <= samp_d;
    dneg_q <= dneg_d;
    dmag_q <= dmag_d;
    wr_q   <= wr_d;
    slot_q <= slot_d;
    out_q  <= out_d;
  end

endmodule

>>> tb/tb_running_range_stats_reservoir_top.sv
// tb_running_range_stats_reservoir_top: self-checking testbench for the running range
// statistics block; runs directed and random samples under several seed/capacity settings
// depends on rrs_pkg and running_range_stats_reservoir_top
`timescale 1ns / 1ps

module tb_running_range_stats_reservoir_top;

  localparam int unsigned Depth = 4096;
  localparam int unsigned CycleLimit = 2000000;
  localparam logic [rrs_pkg::CfgIdxW-1:0] CfgIdxUnused = 8'd2;
  localparam logic [rrs_pkg::CfgIdxW-1:0] CfgIdxTop = 8'hFF;

  typedef struct {
    rrs_pkg::in_item_t  item;
    bit                 typed;
    rrs_pkg::out_item_t result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rrs_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rrs_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rrs_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // predictor state
  logic [31:0]        cnt_q, bad_cnt_q, abs_min_q, abs_max_q;
  logic signed [31:0] min_q, max_q, mean_q;
  logic [63:0]        m2_q, rng_q;
  logic [12:0]        cap_q;
  bit                 ovf_q;
  int unsigned        fill_q;

  rrs_pkg::out_item_t stats_expected[$];
  int unsigned mismatches, results_seen, items_sent, slots_seen;
  int unsigned cycles = 0;
  int unsigned gap_max;
  bit long_hold_req;

  always #6 clk = ~clk;

  running_range_stats_reservoir_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  function automatic rrs_pkg::out_item_t stats_step(rrs_pkg::in_item_t it);
    rrs_pkg::out_item_t r;
    logic [31:0] mag;
    longint d, q, dev;
    longint unsigned ad, adv, prod, z, j;
    int unsigned eff_cap;
    r = '0;
    if (it.not_finite) begin
      if (bad_cnt_q == 32'hFFFF_FFFF) ovf_q = 1'b1;
      else bad_cnt_q++;
    end else if (cnt_q == 32'hFFFF_FFFF) begin
      ovf_q = 1'b1;
    end else begin
      mag = it.sample[31] ? 32'd0 - it.sample : it.sample;
      if (cnt_q == 0) begin
        min_q = it.sample;
        max_q = it.sample;
        abs_min_q = mag;
        abs_max_q = mag;
      end else begin
        if (it.sample < min_q) min_q = it.sample;
        if (it.sample > max_q) max_q = it.sample;
        if (mag > abs_max_q) abs_max_q = mag;
        if (mag < abs_min_q) abs_min_q = mag;
      end
      cnt_q++;
      d = longint'(it.sample) - longint'(mean_q);
      q = d / longint'(cnt_q);
      mean_q = mean_q + q[31:0];
      dev = longint'(it.sample) - longint'(mean_q);
      ad = (d < 0) ? -d : d;
      adv = (dev < 0) ? -dev : dev;
      prod = ad * adv;
      if (m2_q > 64'hFFFF_FFFF_FFFF_FFFF - prod) begin
        m2_q = 64'hFFFF_FFFF_FFFF_FFFF;
        ovf_q = 1'b1;
      end else begin
        m2_q = m2_q + prod;
      end
      eff_cap = (cap_q > Depth) ? Depth : cap_q;
      if (fill_q < eff_cap) begin
        r.slot_index = fill_q[11:0];
        r.slot_written = 1'b1;
        fill_q++;
      end else begin
        rng_q = rng_q + rrs_pkg::GOLDEN_GAMMA;
        z = rng_q;
        z = (z ^ (z >> 30)) * rrs_pkg::MIX_MUL_A;
        z = (z ^ (z >> 27)) * rrs_pkg::MIX_MUL_B;
        z = z ^ (z >> 31);
        j = z % longint'(cnt_q);
        if (j < eff_cap) begin
          r.slot_index = j[11:0];
          r.slot_written = 1'b1;
        end
      end
    end
    r.sample_count = cnt_q;
    r.bad_count = bad_cnt_q;
    r.min_value = min_q;
    r.max_value = max_q;
    r.abs_min_value = abs_min_q;
    r.abs_max_value = abs_max_q;
    r.running_mean = mean_q;
    r.sum_sq_dev = m2_q;
    r.overflow = ovf_q;
    return r;
  endfunction

  task automatic cfg_write(logic [rrs_pkg::CfgIdxW-1:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == rrs_pkg::CFG_RNG_SEED) rng_q = value;
    else if (idx == rrs_pkg::CFG_CAPACITY) cap_q = value[12:0];
  endtask

  task automatic send_sample(rrs_pkg::in_item_t it, bit typed,
                             rrs_pkg::out_item_t typed_result);
    int unsigned gap;
    rrs_pkg::out_item_t r;
    gap = $urandom_range(0, gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = stats_step(it);
    stats_expected.insert(stats_expected.size(), typed ? typed_result : r);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (stats_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic rrs_pkg::in_item_t rand_sample();
    rrs_pkg::in_item_t it;
    it.not_finite = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 99) == 0) it.sample = $urandom;
    else it.sample = $signed($urandom_range(0, 33554431)) - 32'sd16777216;
    return it;
  endfunction

  // receiver: random stalls, one long hold when asked
  initial begin
    int unsigned stall;
    logic [63:0] exp_f[11], act_f[11];
    string names[11];
    rrs_pkg::out_item_t e;
    bit bad;
    bit long_hold_done;
    long_hold_done = 1'b0;
    names = '{"sample_count", "bad_count", "min_value", "max_value", "abs_min_value",
              "abs_max_value", "running_mean", "sum_sq_dev", "slot_index", "slot_written",
              "overflow"};
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, gap_max);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        stall = 600;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_seen++;
      if (out_data.slot_written) slots_seen++;
      if (stats_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        e = stats_expected.pop_front();
        exp_f = '{e.sample_count, e.bad_count, e.min_value, e.max_value, e.abs_min_value,
                  e.abs_max_value, e.running_mean, e.sum_sq_dev, e.slot_index,
                  e.slot_written, e.overflow};
        act_f = '{out_data.sample_count, out_data.bad_count, out_data.min_value,
                  out_data.max_value, out_data.abs_min_value, out_data.abs_max_value,
                  out_data.running_mean, out_data.sum_sq_dev, out_data.slot_index,
                  out_data.slot_written, out_data.overflow};
        bad = 1'b0;
        for (int i = 0; i < 11; i++) begin
          if (exp_f[i] !== act_f[i]) begin
            if (!bad) mismatches++;
            bad = 1'b1;
            if (mismatches <= 10)
              $display("result %0d %s: expected %h got %h", results_seen, names[i],
                       exp_f[i], act_f[i]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t opening[10];
    stim_row_t extremes[11];
    logic [63:0] seeds[7];
    logic [63:0] caps[7];
    int unsigned counts[7];
    cnt_q = '0; bad_cnt_q = '0; abs_min_q = '0; abs_max_q = '0;
    min_q = '0; max_q = '0; mean_q = '0; m2_q = '0; rng_q = '0;
    cap_q = rrs_pkg::CAPACITY_RESET; ovf_q = 1'b0; fill_q = 0;
    mismatches = 0; results_seen = 0; items_sent = 0; slots_seen = 0;
    gap_max = 11;
    long_hold_req = 1'b0;

    // empty statistics, then first sample seeds everything
    opening[0] = '{'{32'h1234_5678, 1'b1}, 1'b1,
                   '{32'd0, 32'd1, 32'sd0, 32'sd0, 32'd0, 32'd0, 32'sd0, 64'd0,
                     12'd0, 1'b0, 1'b0}};
    opening[1] = '{'{32'h0001_0000, 1'b0}, 1'b1,
                   '{32'd1, 32'd1, 32'sh0001_0000, 32'sh0001_0000, 32'h0001_0000,
                     32'h0001_0000, 32'sh0001_0000, 64'd0, 12'd0, 1'b1, 1'b0}};
    opening[2] = '{'{32'hFFFF_0000, 1'b0}, 1'b0, '0};
    opening[3] = '{'{32'h0000_0000, 1'b0}, 1'b0, '0};
    opening[4] = '{'{32'h0000_0001, 1'b0}, 1'b0, '0};
    opening[5] = '{'{32'hFFFF_FFFF, 1'b0}, 1'b0, '0};
    opening[6] = '{'{32'hFFFF_FFFF, 1'b1}, 1'b0, '0};
    opening[7] = '{'{32'h0000_8000, 1'b0}, 1'b0, '0};
    opening[8] = '{'{32'hFFFE_8000, 1'b0}, 1'b0, '0};
    opening[9] = '{'{32'h0000_0000, 1'b1}, 1'b0, '0};
    // full-scale swings drive M2 into saturation
    for (int i = 0; i < 10; i++)
      extremes[i] = '{'{(i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000, 1'b0}, 1'b0, '0};
    extremes[10] = '{'{32'h8000_0000, 1'b1}, 1'b0, '0};

    // seed, capacity, sample count per random phase
    seeds  = '{64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0};
    caps   = '{64'd0, 64'd5, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd1, 64'd4096, 64'd0};
    counts = '{150, 400, 200, 350, 250, 250, 100};
    for (int p = 1; p < 7; p++) seeds[p] = {$urandom, $urandom};
    caps[3] = $urandom_range(2, 64);
    caps[6] = $urandom_range(0, 8191);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening[i]) send_sample(opening[i].item, opening[i].typed, opening[i].result);
    drain();

    for (int p = 0; p < 7; p++) begin
      cfg_write(rrs_pkg::CFG_RNG_SEED, seeds[p]);
      cfg_write(rrs_pkg::CFG_CAPACITY, caps[p]);
      if (p == 2) begin
        // writes to unused indexes must not disturb anything
        cfg_write(CfgIdxUnused, 64'hDEAD_BEEF_0000_0001);
        cfg_write(CfgIdxTop, 64'h0);
      end
      @(negedge clk);
      cfg_valid <= 1'b0;
      gap_max = (p == 3) ? 0 : 11;
      if (p == 1) long_hold_req = 1'b1;
      for (int n = 0; n < counts[p]; n++) send_sample(rand_sample(), 1'b0, '0);
      drain();
    end

    gap_max = 11;
    foreach (extremes[i]) send_sample(extremes[i].item, 1'b0, '0);
    drain();
    repeat (150) @(posedge clk);

    if (stats_expected.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", stats_expected.size());
    end
    $display("sent %0d samples over 7 seed/capacity settings, checked %0d results",
             items_sent, results_seen);
    $display("%0d reservoir slot writes, final overflow %0b", slots_seen, ovf_q);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatching results", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/rrs_pkg.sv
hw/rtl/rrs_iter_unit.sv
hw/rtl/running_range_stats_reservoir_top.sv
tb/tb_running_range_stats_reservoir_top.sv
